// File: src/jls_pkg.sv
// Package with the shared widths, codes and types of the Jacobi grid solver.
package jls_pkg;

  // Grid store geometry.
  localparam int GRID_MAX = 256;
  localparam int COORD_W  = $clog2(GRID_MAX);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int CELLS    = GRID_MAX * GRID_MAX;

  // Field widths.
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int SIZE_W   = 9;
  localparam int COUNT_W  = 20;
  localparam int CFG_IDX_W = 2;

  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Operation codes.
  localparam opcode_t OP_LOAD = 2'd0;
  localparam opcode_t OP_RUN  = 2'd1;
  localparam opcode_t OP_READ = 2'd2;

  // Result kinds.
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t REG_GRID_SIZE  = 2'd0;
  localparam cfg_idx_t REG_TOLERANCE  = 2'd1;
  localparam cfg_idx_t REG_ITER_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam size_t  GRID_SIZE_RST  = 9'd256;
  localparam value_t TOLERANCE_RST  = 32'd17;
  localparam count_t ITER_LIMIT_RST = 20'd1000000;

  // Side length in use, saturated to the store size.
  function automatic size_t sat_size(input size_t n);
    sat_size = (n > size_t'(GRID_MAX)) ? size_t'(GRID_MAX) : n;
  endfunction

endpackage

// File: src/jls_chan_if.sv
// Interfaces for the command, result and configuration channels of the solver.
interface jls_in_if;
  import jls_pkg::*;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  coord_t  row;
  coord_t  column;
  value_t  cell_value;
  modport source (output valid, output opcode, output row, output column,
                  output cell_value, input ready);
  modport sink   (input valid, input opcode, input row, input column,
                  input cell_value, output ready);
endinterface

interface jls_out_if;
  import jls_pkg::*;
  logic   valid;
  logic   ready;
  logic   result_kind;
  value_t read_value;
  count_t sweeps_done;
  value_t final_change;
  modport source (output valid, output result_kind, output read_value,
                  output sweeps_done, output final_change, input ready);
  modport sink   (input valid, input result_kind, input read_value,
                  input sweeps_done, input final_change, output ready);
endinterface

interface jls_cfg_if;
  import jls_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  value_t   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/jacobi_laplace_grid_solver.sv
// Jacobi five-point Laplace solver over a ping-pong pair of grid memories.
//
// Channels: in_chan takes commands (load cell, run solver, read cell),
// out_chan returns read results and run reports, cfg_chan writes the
// grid size, tolerance and iteration limit registers (always ready).
// A load writes the cell into both grid copies; loads are taken back to
// back, also while a result waits on out_chan. A read's cell passes the
// memory read register and then the output register; the next command
// is taken once the read has reached the output register.
// A run walks the interior cell by cell in an order set by the two read
// ports of the source memory (up and down, left and right, centre, then
// write-back). For a side below 3 a sweep walks no cells. After the last
// sweep the report is loaded into the output register from the idle
// state once that register is free.
// No command is taken while a run is in progress.
// Reset clears the control state and the registers to their reset values;
// the grid memories are not cleared and must be loaded before use.
// When the receiver stalls, the result is held in the output register;
// reads and runs wait for it to empty, loads carry on.
module jacobi_laplace_grid_solver (
  input logic    clk,
  input logic    rst_n,
  jls_in_if.sink   in_chan,
  jls_out_if.source out_chan,
  jls_cfg_if.sink  cfg_chan
);
  import jls_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_UD     = 3'd2;
  localparam logic [2:0] S_LR     = 3'd3;
  localparam logic [2:0] S_C      = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;
  localparam logic [2:0] S_FOLD   = 3'd6;
  localparam logic [2:0] S_END    = 3'd7;

  // Configuration registers.
  size_t  grid_size_r;
  value_t tolerance_r;
  count_t iter_limit_r;

  // Control state.
  logic [2:0] state_r;
  logic       report_pend_r;
  logic       rd_pend_r;
  logic       cur_r;
  size_t      n_r;
  coord_t     i_r;
  coord_t     j_r;
  count_t     sweeps_r;
  value_t     change_r;
  value_t     worst_r;
  value_t     diff_r;
  logic       diff_v_r;
  logic [VALUE_W+1:0] sum_r;

  // Output register.
  logic   out_valid_r;
  logic   out_kind_r;
  value_t out_value_r;
  count_t out_sweeps_r;
  value_t out_change_r;

  // Grid memories with two registered read ports each.
  value_t grid0_mem [CELLS];
  value_t grid1_mem [CELLS];
  value_t q0a_r, q0b_r, q1a_r, q1b_r;

  addr_t  rd_addr_a;
  addr_t  rd_addr_b;
  addr_t  wr_addr;
  value_t wr_data;
  logic   we0;
  logic   we1;

  logic   in_xfer;
  logic   out_xfer;
  logic   out_free;
  value_t qa;
  value_t qb;
  value_t fresh;
  size_t  last_idx;
  logic   row_end;
  logic   col_end;
  count_t sweeps_inc;
  logic   more_sweeps;

  // Handshakes.
  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && !report_pend_r && !rd_pend_r &&
                         (out_free || (in_chan.opcode != OP_RUN &&
                                       in_chan.opcode != OP_READ));
  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign out_xfer  = out_valid_r && out_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Read data of the current source copy.
  assign qa = cur_r ? q1a_r : q0a_r;
  assign qb = cur_r ? q1b_r : q0b_r;
  assign fresh = sum_r[VALUE_W+1:2];

  // Position in the interior walk.
  assign last_idx = n_r - size_t'(2);
  assign col_end  = ({1'b0, j_r} == last_idx);
  assign row_end  = ({1'b0, i_r} == last_idx);
  assign sweeps_inc  = sweeps_r + count_t'(1);
  assign more_sweeps = (worst_r > tolerance_r) && (sweeps_inc < iter_limit_r);

  // Memory addressing and write enables.
  always_comb begin
    rd_addr_a = {in_chan.row, in_chan.column};
    rd_addr_b = {i_r + coord_t'(1), j_r};
    unique case (state_r)
      S_UD: begin
        rd_addr_a = {i_r - coord_t'(1), j_r};
        rd_addr_b = {i_r + coord_t'(1), j_r};
      end
      S_LR: begin
        rd_addr_a = {i_r, j_r - coord_t'(1)};
        rd_addr_b = {i_r, j_r + coord_t'(1)};
      end
      S_C: begin
        rd_addr_a = {i_r, j_r};
      end
      default: begin
        rd_addr_a = {in_chan.row, in_chan.column};
      end
    endcase
  end

  always_comb begin
    if (state_r == S_UPD) begin
      wr_addr = {i_r, j_r};
      wr_data = fresh;
      we0     = cur_r;
      we1     = !cur_r;
    end else begin
      wr_addr = {in_chan.row, in_chan.column};
      wr_data = in_chan.cell_value;
      we0     = in_xfer && (in_chan.opcode == OP_LOAD);
      we1     = in_xfer && (in_chan.opcode == OP_LOAD);
    end
  end

  // Grid copy zero.
  always_ff @(posedge clk) begin
    if (we0) begin
      grid0_mem[wr_addr] <= wr_data;
    end
    q0a_r <= grid0_mem[rd_addr_a];
    q0b_r <= grid0_mem[rd_addr_b];
  end

  // Grid copy one.
  always_ff @(posedge clk) begin
    if (we1) begin
      grid1_mem[wr_addr] <= wr_data;
    end
    q1a_r <= grid1_mem[rd_addr_a];
    q1b_r <= grid1_mem[rd_addr_b];
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= GRID_SIZE_RST;
      tolerance_r  <= TOLERANCE_RST;
      iter_limit_r <= ITER_LIMIT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_GRID_SIZE:  grid_size_r  <= cfg_chan.data[SIZE_W-1:0];
        REG_TOLERANCE:  tolerance_r  <= cfg_chan.data;
        REG_ITER_LIMIT: iter_limit_r <= cfg_chan.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stencil datapath: partial sums and change of the cell just written.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LR:  sum_r <= {2'b00, qa} + {2'b00, qb};
      S_C:   sum_r <= sum_r + {2'b00, qa} + {2'b00, qb};
      S_UPD: diff_r <= (fresh > qa) ? (fresh - qa) : (qa - fresh);
      default: begin
      end
    endcase
  end

  // Sweep sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      report_pend_r <= 1'b0;
      cur_r         <= 1'b0;
      diff_v_r      <= 1'b0;
      sweeps_r      <= '0;
      change_r      <= '0;
      worst_r       <= '0;
      n_r           <= GRID_SIZE_RST;
      i_r           <= '0;
      j_r           <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (report_pend_r && out_free) begin
            report_pend_r <= 1'b0;
          end
          if (in_xfer && in_chan.opcode == OP_RUN) begin
            n_r      <= sat_size(grid_size_r);
            sweeps_r <= '0;
            change_r <= '0;
            if (iter_limit_r == '0) begin
              report_pend_r <= 1'b1;
            end else begin
              state_r <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          worst_r  <= '0;
          diff_v_r <= 1'b0;
          i_r      <= coord_t'(1);
          j_r      <= coord_t'(1);
          state_r  <= (n_r < size_t'(3)) ? S_END : S_UD;
        end
        S_UD: begin
          // Fold in the change of the previous cell.
          if (diff_v_r && diff_r > worst_r) begin
            worst_r <= diff_r;
          end
          diff_v_r <= 1'b0;
          state_r  <= S_LR;
        end
        S_LR: begin
          state_r <= S_C;
        end
        S_C: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          diff_v_r <= 1'b1;
          if (col_end) begin
            j_r <= coord_t'(1);
            if (row_end) begin
              state_r <= S_FOLD;
            end else begin
              i_r     <= i_r + coord_t'(1);
              state_r <= S_UD;
            end
          end else begin
            j_r     <= j_r + coord_t'(1);
            state_r <= S_UD;
          end
        end
        S_FOLD: begin
          if (diff_v_r && diff_r > worst_r) begin
            worst_r <= diff_r;
          end
          diff_v_r <= 1'b0;
          state_r  <= S_END;
        end
        S_END: begin
          // The copies swap roles after every sweep.
          cur_r    <= !cur_r;
          sweeps_r <= sweeps_inc;
          change_r <= worst_r;
          if (more_sweeps) begin
            state_r <= S_SWEEP;
          end else begin
            report_pend_r <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Read tracking: the cell arrives from the memory read register while this flag is set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= in_xfer && (in_chan.opcode == OP_READ);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r) begin
      out_valid_r <= 1'b1;
    end else if (report_pend_r && state_r == S_IDLE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_kind_r   <= KIND_READ;
      out_value_r  <= qa;
      out_sweeps_r <= '0;
      out_change_r <= '0;
    end else if (report_pend_r && state_r == S_IDLE && out_free) begin
      out_kind_r   <= KIND_REPORT;
      out_value_r  <= '0;
      out_sweeps_r <= sweeps_r;
      out_change_r <= change_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_kind  = out_kind_r;
  assign out_chan.read_value   = out_value_r;
  assign out_chan.sweeps_done  = out_sweeps_r;
  assign out_chan.final_change = out_change_r;

endmodule
